// ===== hw/rtl/swsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types, constants and helpers of the single-wire sensor reader.
// ----------------------------------------------------------------------------
package swsr_pkg;

   localparam int FRAME_BITS  = 40;
   localparam int COUNT_WIDTH = 16;
   localparam int INDEX_WIDTH = $clog2(FRAME_BITS);
   localparam int NUM_BYTES   = 5;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [15:0] START_HOLD_RESET = 16'd18000;
   localparam logic [7:0]  SETUP_MIN_RESET  = 8'd80;
   localparam logic [7:0]  THRESHOLD_RESET  = 8'd50;

   // Configuration register indexes.
   localparam logic [1:0] REG_START_HOLD = 2'd0;
   localparam logic [1:0] REG_SETUP_MIN  = 2'd1;
   localparam logic [1:0] REG_THRESHOLD  = 2'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HOLD      = 3'd1,
      PH_RELEASED  = 3'd2,
      PH_RESP_LOW  = 3'd3,
      PH_RESP_HIGH = 3'd4,
      PH_BIT_LOW   = 3'd5,
      PH_BIT_HIGH  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SETUP    = 2'd1,
      STATUS_CHECKSUM = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] start_hold_us;
      logic [7:0]  setup_min_us;
      logic [7:0]  bit_threshold_us;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      status_type status;
      logic [7:0] humid_int;
      logic [7:0] humid_frac;
      logic [7:0] temp_int;
      logic [7:0] temp_frac;
      logic [7:0] check_byte;
   } result_type;

   // Byte k of the frame, counted from the first bit received. A byte that
   // lies beyond the frame reads as zero.
   function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] bits,
                                             input int k);
      int top;
      logic [FRAME_BITS-1:0] shifted;
      top = 8 * (k + 1);
      shifted = bits >> (FRAME_BITS - top);
      if (top > FRAME_BITS) begin
         return 8'd0;
      end
      return shifted[7:0];
   endfunction

endpackage

// ===== hw/rtl/swsr_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_csr
// Configuration registers: start hold time, setup minimum, bit threshold.
// ----------------------------------------------------------------------------
module swsr_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output swsr_pkg::cfg_type  cfg
);

   swsr_pkg::cfg_type cfg_ff;
   swsr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            swsr_pkg::REG_START_HOLD: cfg_in.start_hold_us    = csr_data;
            swsr_pkg::REG_SETUP_MIN:  cfg_in.setup_min_us     = csr_data[7:0];
            swsr_pkg::REG_THRESHOLD:  cfg_in.bit_threshold_us = csr_data[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_hold_us    <= swsr_pkg::START_HOLD_RESET;
         cfg_ff.setup_min_us     <= swsr_pkg::SETUP_MIN_RESET;
         cfg_ff.bit_threshold_us <= swsr_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/swsr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsr_engine
// Reader state and its one-step update: phase sequencer, pulse timer,
// bit shifter and checksum compare. The result reflects the updated state.
// ----------------------------------------------------------------------------
module swsr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  opcode,
   input  logic                  line_level,
   input  swsr_pkg::cfg_type     cfg,
   output swsr_pkg::result_type  result
);

   swsr_pkg::phase_type                 phase_ff, phase_in;
   logic [swsr_pkg::COUNT_WIDTH-1:0]    tick_ff, tick_in;
   logic [swsr_pkg::INDEX_WIDTH-1:0]    index_ff, index_in;
   logic [swsr_pkg::FRAME_BITS-1:0]     bits_ff, bits_in;
   swsr_pkg::status_type                status_ff, status_in;
   logic                                done;

   logic [swsr_pkg::COUNT_WIDTH-1:0]    tick_inc;
   logic                                bit_value;
   logic [swsr_pkg::FRAME_BITS-1:0]     shifted;
   logic [7:0]                          sum;
   logic [swsr_pkg::INDEX_WIDTH:0]      index_next;
   logic                                frame_end;

   assign tick_inc = (tick_ff == swsr_pkg::COUNT_MAX) ? tick_ff
                   : tick_ff + {{(swsr_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
   assign bit_value = (tick_ff > {{(swsr_pkg::COUNT_WIDTH-8){1'b0}}, cfg.bit_threshold_us});
   assign shifted = {bits_ff[swsr_pkg::FRAME_BITS-2:0], bit_value};
   assign sum = swsr_pkg::frame_byte(shifted, 0) + swsr_pkg::frame_byte(shifted, 1)
              + swsr_pkg::frame_byte(shifted, 2) + swsr_pkg::frame_byte(shifted, 3);
   assign index_next = {1'b0, index_ff} + {{swsr_pkg::INDEX_WIDTH{1'b0}}, 1'b1};
   assign frame_end = (index_next >= (swsr_pkg::INDEX_WIDTH+1)'(swsr_pkg::FRAME_BITS));

   localparam logic [swsr_pkg::COUNT_WIDTH-1:0] ONE = {{(swsr_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      index_in  = index_ff;
      bits_in   = bits_ff;
      status_in = status_ff;
      done      = 1'b0;
      if (opcode == swsr_pkg::OP_START) begin
         // A start request while a reading runs is ignored.
         if (phase_ff == swsr_pkg::PH_IDLE) begin
            phase_in  = swsr_pkg::PH_HOLD;
            tick_in   = '0;
            index_in  = '0;
            bits_in   = '0;
            status_in = swsr_pkg::STATUS_OK;
         end
      end else begin
         case (phase_ff)
            swsr_pkg::PH_IDLE: begin
               phase_in = swsr_pkg::PH_IDLE;
            end
            swsr_pkg::PH_HOLD: begin
               tick_in = tick_inc;
               if (tick_inc >= cfg.start_hold_us) begin
                  phase_in = swsr_pkg::PH_RELEASED;
               end
            end
            swsr_pkg::PH_RELEASED: begin
               if (!line_level) begin
                  phase_in = swsr_pkg::PH_RESP_LOW;
                  tick_in  = ONE;
               end
            end
            swsr_pkg::PH_RESP_LOW: begin
               if (!line_level) begin
                  tick_in = ONE;
               end else begin
                  phase_in = swsr_pkg::PH_RESP_HIGH;
                  tick_in  = tick_inc;
               end
            end
            swsr_pkg::PH_RESP_HIGH: begin
               if (line_level) begin
                  tick_in = tick_inc;
               end else if (tick_ff < {{(swsr_pkg::COUNT_WIDTH-8){1'b0}}, cfg.setup_min_us}) begin
                  status_in = swsr_pkg::STATUS_SETUP;
                  done      = 1'b1;
                  phase_in  = swsr_pkg::PH_IDLE;
               end else begin
                  phase_in = swsr_pkg::PH_BIT_LOW;
                  tick_in  = ONE;
                  index_in = '0;
               end
            end
            swsr_pkg::PH_BIT_LOW: begin
               if (!line_level) begin
                  tick_in = ONE;
               end else begin
                  phase_in = swsr_pkg::PH_BIT_HIGH;
                  tick_in  = tick_inc;
               end
            end
            swsr_pkg::PH_BIT_HIGH: begin
               if (line_level) begin
                  tick_in = tick_inc;
               end else begin
                  bits_in = shifted;
                  if (frame_end) begin
                     status_in = (sum == swsr_pkg::frame_byte(shifted, 4))
                               ? swsr_pkg::STATUS_OK : swsr_pkg::STATUS_CHECKSUM;
                     done      = 1'b1;
                     phase_in  = swsr_pkg::PH_IDLE;
                     index_in  = '0;
                  end else begin
                     index_in = index_next[swsr_pkg::INDEX_WIDTH-1:0];
                     phase_in = swsr_pkg::PH_BIT_LOW;
                     tick_in  = ONE;
                  end
               end
            end
            default: begin
               phase_in = swsr_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= swsr_pkg::PH_IDLE;
         tick_ff   <= '0;
         index_ff  <= '0;
         bits_ff   <= '0;
         status_ff <= swsr_pkg::STATUS_OK;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         index_ff  <= index_in;
         bits_ff   <= bits_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      result.drive_low  = (phase_in == swsr_pkg::PH_HOLD);
      result.busy_res   = (phase_in != swsr_pkg::PH_IDLE);
      result.done_res   = done;
      result.status     = status_in;
      result.humid_int  = swsr_pkg::frame_byte(bits_in, 0);
      result.humid_frac = swsr_pkg::frame_byte(bits_in, 1);
      result.temp_int   = swsr_pkg::frame_byte(bits_in, 2);
      result.temp_frac  = swsr_pkg::frame_byte(bits_in, 3);
      result.check_byte = swsr_pkg::frame_byte(bits_in, 4);
   end

endmodule

// ===== hw/rtl/single_wire_sensor_reader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_sensor_reader
// Times the pulses of a single-wire humidity/temperature sensor, one sampled
// line level per tick, and reports the received frame and its status.
// ----------------------------------------------------------------------------
//   channel   ports                     direction   transaction
//   req       valid/ready, opcode,line  in          tick or start request
//   rsp       valid/ready, 9 fields     out         one result per request
//   csr       valid/ready, index,data   in          register write
//
// One transaction per cycle is sustained while results are taken. A transaction
// accepted sits in the input register and moves into the result register once
// that register is empty or its result is taken, and is then offered there.
// The reader state advances only when the input register moves into the
// result register, so a stalled result holds the whole pipe in place.
// Synchronous active-high reset restores idle and the register defaults.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_drive_low,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_humid_int,
   output logic [7:0]  rsp_humid_frac,
   output logic [7:0]  rsp_temp_int,
   output logic [7:0]  rsp_temp_frac,
   output logic [7:0]  rsp_check_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   swsr_pkg::cfg_type    cfg;
   swsr_pkg::result_type result;
   swsr_pkg::result_type rsp_ff;

   logic s1_valid_ff, s1_valid_in;
   logic s1_opcode_ff;
   logic s1_line_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   assign csr_ready = 1'b1;

   swsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   swsr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .opcode     (s1_opcode_ff),
      .line_level (s1_line_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff <= req_opcode;
         s1_line_ff   <= req_line_level;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive_low  = rsp_ff.drive_low;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_status     = rsp_ff.status;
   assign rsp_humid_int  = rsp_ff.humid_int;
   assign rsp_humid_frac = rsp_ff.humid_frac;
   assign rsp_temp_int   = rsp_ff.temp_int;
   assign rsp_temp_frac  = rsp_ff.temp_frac;
   assign rsp_check_byte = rsp_ff.check_byte;

   // A finished reading always leaves the reader idle.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.done_res && rsp_ff.busy_res))
      else $error("done reported while still busy");

   // The wire is only driven during a reading.
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_low |-> rsp_ff.busy_res)
      else $error("wire driven while idle");

   // A setup failure happens before any data bit is shifted in.
   a_setup_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res && rsp_ff.status == swsr_pkg::STATUS_SETUP
      |-> (rsp_ff.humid_int == 8'd0) && (rsp_ff.humid_frac == 8'd0)
          && (rsp_ff.temp_int == 8'd0) && (rsp_ff.temp_frac == 8'd0)
          && (rsp_ff.check_byte == 8'd0))
      else $error("setup failure with data bits");

   // A held input register keeps its transaction.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_opcode_ff)
                                  && $stable(s1_line_ff))
      else $error("input register lost a transaction");

endmodule
